// ----- hw/rtl/wspm_pkg.sv -----
// Shared types and constants for the wildcard star pattern matcher.
// No dependencies; used by the cell, the result buffer and the top level.

package wspm_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int SYM_W       = 8;
	localparam int RES_W       = 2;
	localparam int OUT_W       = ((RES_W + 7) / 8) * 8;

	localparam logic [SYM_W-1:0] DOT_BYTE  = 8'h2E;
	localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		logic             clear;
		logic             text;
		logic             fresh;
		logic [SYM_W-1:0] sym;
	} cell_ctrl_t;

	// Result fields, matched in the low bit.
	typedef struct packed {
		logic overflow;
		logic matched;
	} result_t;

endpackage

// ----- hw/rtl/wspm_cell.sv -----
// One pattern position of the matcher chain: its byte, star mark and active bit.
// Depends on wspm_pkg; instantiated in a row by the top level.

module wspm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wspm_pkg::cell_ctrl_t ctrl,
	input  logic                seed,
	input  logic                wr,
	input  logic                mark_set,
	input  logic                adv_in,
	input  logic                skip_in,
	output logic                adv_out,
	output logic                skip_out,
	output logic                act
);
	import wspm_pkg::*;

	logic [SYM_W-1:0] byte_q;
	logic             mark_q;
	logic             used_q;
	logic             act_q;

	logic act_eff;
	logic match;
	logic hit;
	logic raw;
	logic mark_eff;
	logic closed;

	always_comb begin
		// Right after a start item position zero is active before it is stored.
		act_eff  = act_q | (seed & ctrl.fresh);
		match    = used_q && ((byte_q == ctrl.sym) || (byte_q == DOT_BYTE));
		hit      = act_eff & match;
		raw      = (ctrl.text ? (hit & mark_q) : act_eff) | adv_in;
		mark_eff = mark_set | (mark_q & ~wr);
		closed   = raw | skip_in;
		skip_out = closed & mark_eff;
		adv_out  = ctrl.text & hit & ~mark_q;
		act      = act_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			mark_q <= 1'b0;
			used_q <= 1'b0;
		end else if (ctrl.clear) begin
			act_q  <= 1'b0;
			mark_q <= 1'b0;
			used_q <= 1'b0;
		end else begin
			act_q  <= closed;
			mark_q <= mark_eff;
			if (wr) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			byte_q <= ctrl.sym;
		end
	end

endmodule

// ----- hw/rtl/wspm_skid.sv -----
// Two-entry result buffer: output register plus skid register.
// Depends on wspm_pkg for the result type.

module wspm_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wspm_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output wspm_pkg::result_t out_data
);
	import wspm_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    load;

	assign load      = !out_valid_q || out_ready;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// ----- hw/rtl/wildcard_star_pattern_matcher.sv -----
// Top level of the wildcard star pattern matcher: control, cell chain, result buffer.
// Depends on wspm_pkg, wspm_cell and wspm_skid.
//
// Usage: items enter on the s_ channel. s_tuser carries the operation (start,
// append pattern byte, text byte, finish) and s_tdata the byte. A start item
// clears the job; pattern bytes follow, then text bytes; a finish item returns
// one result item on the m_ channel with matched in bit 0 and overflow in bit 1.
// Pattern bytes after the first text or finish item are ignored; bytes beyond the store
// set overflow and force matched low.
// Throughput: one item per cycle of any kind while s_tready is high. Every text byte is applied to all
// pattern positions at once; the star closure ripples through the row of cells
// in the same cycle, so the cell chain sets the clock, not the rate.
// Result: the result of a finish item is registered in the output register, or in the
// skid register while the output stalls, before m_tvalid shows it.
// Stall: an output register and a skid register hold up to two results; only
// when both are full does s_tready fall, and it rises again as soon as the
// receiver takes a result.
// Reset: the job is empty, as after a start item, and no result is pending.

module wildcard_star_pattern_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [wspm_pkg::SYM_W-1:0]  s_tdata,  // [7:0] symbol
	input  logic [1:0]                  s_tuser,  // [1:0] operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wspm_pkg::OUT_W-1:0]  m_tdata   // [0] matched, [1] overflow, rest zero
);
	import wspm_pkg::*;

	logic             accept;
	op_t              op;
	logic             is_start;
	logic             is_text;
	logic             is_finish;
	logic             is_append;
	logic             full_len;
	logic             app_ok;

	logic [LEN_W-1:0] len_q;
	logic             started_q;
	logic             ovf_q;
	logic             fresh_q;
	logic             fin_q;
	logic             fin_raw;
	logic             fin_next;

	cell_ctrl_t       ctrl;
	logic             adv  [0:MAX_PATTERN];
	logic             skip [0:MAX_PATTERN+1];
	logic [MAX_PATTERN:0] act_vec;

	result_t          res;
	result_t          out_res;
	logic             buf_full;

	assign accept    = s_tvalid && s_tready;
	assign op        = op_t'(s_tuser);
	assign is_start  = accept && (op == OP_START);
	assign is_append = accept && (op == OP_APPEND) && !started_q;
	assign is_text   = accept && (op == OP_TEXT);
	assign is_finish = accept && (op == OP_FINISH);
	assign full_len  = (len_q == LEN_W'(MAX_PATTERN));
	assign app_ok    = is_append && !full_len;

	assign ctrl.clear = is_start;
	assign ctrl.text  = is_text;
	assign ctrl.fresh = fresh_q;
	assign ctrl.sym   = s_tdata;

	assign adv[0]  = 1'b0;
	assign skip[0] = 1'b0;
	assign skip[1] = 1'b0;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic wr;
		logic mark_set;

		assign wr       = app_ok && (len_q == LEN_W'(j));
		assign mark_set = app_ok && (s_tdata == STAR_BYTE) && (len_q == LEN_W'(j + 1));

		wspm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.seed     ((j == 0) ? 1'b1 : 1'b0),
			.wr       (wr),
			.mark_set (mark_set),
			.adv_in   (adv[j]),
			.skip_in  (skip[j]),
			.adv_out  (adv[j+1]),
			.skip_out (skip[j+2]),
			.act      (act_vec[j])
		);
	end

	// The position past a full store has no byte; it is only ever entered.
	assign fin_raw  = (is_text ? 1'b0 : fin_q) | adv[MAX_PATTERN];
	assign fin_next = fin_raw | skip[MAX_PATTERN] | skip[MAX_PATTERN+1];
	assign act_vec[MAX_PATTERN] = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
			fresh_q   <= 1'b1;
			fin_q     <= 1'b0;
		end else begin
			fresh_q <= is_start;
			if (is_start) begin
				len_q     <= '0;
				started_q <= 1'b0;
				ovf_q     <= 1'b0;
				fin_q     <= 1'b0;
			end else begin
				fin_q <= fin_next;
				if (is_text || is_finish) begin
					started_q <= 1'b1;
				end
				if (app_ok) begin
					len_q <= len_q + LEN_W'(1);
				end
				if (is_append && full_len) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	assign res.matched  = act_vec[len_q] && !ovf_q;
	assign res.overflow = ovf_q;

	wspm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (is_finish),
		.push_data (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign s_tready = !buf_full;
	assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, out_res};

endmodule

// ----- hw/rtl/wspm_checker.sv -----
// Port-level checks for the wildcard star pattern matcher, bound to the top level.
// Depends on wspm_pkg for the operation codes.

module wspm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [wspm_pkg::SYM_W-1:0] s_tdata,
	input logic [1:0]                 s_tuser,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [wspm_pkg::OUT_W-1:0] m_tdata
);
	import wspm_pkg::*;

	logic acc;
	assign acc = s_tvalid && s_tready;

	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// A finish item into an empty buffer shows up on the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_tuser == OP_FINISH) && !m_tvalid |=> m_tvalid)
		else $error("finish item produced no result");

	// An overflowed pattern never reports a match.
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("match reported with overflow");

	// An empty pattern matches empty text.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (s_tuser == OP_START) ##1 acc && (s_tuser == OP_FINISH) && !m_tvalid
		|=> m_tdata[1:0] == 2'b01)
		else $error("empty job did not match");

endmodule

bind wildcard_star_pattern_matcher wspm_checker u_wspm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- bench/wildcard_star_pattern_matcher_tb.sv -----
// Self-checking bench for wildcard_star_pattern_matcher: a directed table, then random jobs.
// Verdicts come from a position-set predictor kept in step with accepted items.
// Depends on wspm_pkg and the matcher RTL only.

module wildcard_star_pattern_matcher_tb;
	import wspm_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam longint      LIMIT_CYCLES = 600000;

	localparam logic [SYM_W-1:0] SYM_A = "a";
	localparam logic [SYM_W-1:0] SYM_B = "b";
	localparam logic [SYM_W-1:0] SYM_Q = "q";
	localparam logic [SYM_W-1:0] SYM_Z = "z";

	typedef struct packed {
		op_t              op;
		logic [SYM_W-1:0] sym;
		logic [7:0]       reps;
		logic             typed;
		result_t          want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [SYM_W-1:0] s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// Sideband that travels with the item on offer: a verdict typed into the table.
	logic    tag_typed;
	result_t tag_fixed;

	// Predictor state.
	logic [SYM_W-1:0]       pat_store [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pat_starred;
	int                     pat_len;
	logic [MAX_PATTERN+1:0] live_pos;
	bit                     text_seen;
	bit                     pat_over;

	result_t     verdict_queue [$];
	stim_row_t   dir_rows [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned verdicts_seen = 0;
	int unsigned matches_seen = 0;
	int unsigned overflows_seen = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	wildcard_star_pattern_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic void clear_job();
		pat_starred = '0;
		pat_len = 0;
		live_pos = '0;
		text_seen = 1'b0;
		pat_over = 1'b0;
	endfunction

	// Add every position reached by skipping starred tokens; chains only run upward.
	function automatic logic [MAX_PATTERN+1:0] star_closure(input logic [MAX_PATTERN+1:0] set);
		for (int j = 0; j < pat_len && j < MAX_PATTERN; j++)
			if (set[j] && pat_starred[j])
				set[j+2] = 1'b1;
		return set;
	endfunction

	function automatic void open_text();
		if (!text_seen) begin
			live_pos = star_closure((MAX_PATTERN+2)'(1));
			text_seen = 1'b1;
		end
	endfunction

	function automatic void advance_matcher(input op_t op, input logic [SYM_W-1:0] sym,
	                                        output bit has_res, output result_t res);
		logic [MAX_PATTERN+1:0] nxt;
		has_res = 1'b0;
		res = '0;
		case (op)
		OP_START: begin
			clear_job();
		end
		OP_APPEND: begin
			if (!text_seen) begin
				if (pat_len >= MAX_PATTERN) begin
					pat_over = 1'b1;
				end else begin
					pat_store[pat_len] = sym;
					pat_starred[pat_len] = 1'b0;
					if (sym == STAR_BYTE && pat_len > 0)
						pat_starred[pat_len-1] = 1'b1;
					pat_len++;
				end
			end
		end
		OP_TEXT: begin
			open_text();
			nxt = '0;
			for (int j = 0; j < pat_len && j < MAX_PATTERN; j++) begin
				if (live_pos[j] && (pat_store[j] == sym || pat_store[j] == DOT_BYTE)) begin
					if (pat_starred[j])
						nxt[j] = 1'b1;
					else
						nxt[j+1] = 1'b1;
				end
			end
			live_pos = star_closure(nxt);
		end
		default: begin
			open_text();
			has_res = 1'b1;
			res.overflow = pat_over;
			res.matched = live_pos[pat_len] && !pat_over;
		end
		endcase
	endfunction

	always @(posedge clk) begin : verdict_check
		bit      has_res;
		result_t res;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_matcher(op_t'(s_tuser), s_tdata, has_res, res);
				if (has_res)
					verdict_queue.push_back(tag_typed ? tag_fixed : res);
			end
			if (m_tvalid && m_tready) begin
				verdicts_seen++;
				if (verdict_queue.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got tdata %0h", $time, m_tdata);
				end else begin
					want = verdict_queue.pop_front();
					matches_seen += want.matched;
					overflows_seen += want.overflow;
					if (m_tdata[0] !== want.matched) begin
						mismatches++;
						$display("%0t: matched expected %0b, actual %0b", $time, want.matched,
						         m_tdata[0]);
					end
					if (m_tdata[1] !== want.overflow) begin
						mismatches++;
						$display("%0t: overflow expected %0b, actual %0b", $time, want.overflow,
						         m_tdata[1]);
					end
					if (m_tdata[OUT_W-1:RES_W] !== '0) begin
						mismatches++;
						$display("%0t: padding expected 0, actual %0h", $time,
						         m_tdata[OUT_W-1:RES_W]);
					end
				end
			end
		end
	end

	// Receiver: short random stalls, a few long ones, and one long hold-off on request.
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
				                                          : $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [SYM_W-1:0] pick_text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return SYM_A;
		if (r < 70)
			return SYM_B;
		return SYM_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [SYM_W-1:0] pick_pattern_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return SYM_A;
		if (r < 45)
			return SYM_B;
		if (r < 60)
			return DOT_BYTE;
		if (r < 80)
			return STAR_BYTE;
		return SYM_W'($urandom_range(0, 255));
	endfunction

	function automatic void add_row(input op_t op, input logic [SYM_W-1:0] sym,
	                                input int reps = 1, input bit typed = 1'b0,
	                                input bit want_match = 1'b0, input bit want_ovf = 1'b0);
		stim_row_t row;
		row.op = op;
		row.sym = sym;
		row.reps = 8'(reps);
		row.typed = typed;
		row.want.matched = want_match;
		row.want.overflow = want_ovf;
		dir_rows.push_back(row);
	endfunction

	task automatic send_item(input op_t op, input logic [SYM_W-1:0] sym,
	                         input bit typed = 1'b0, input result_t fixed = '0);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= sym;
		tag_typed <= typed;
		tag_fixed <= fixed;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// The sender withdraws its offer, then waits until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (verdict_queue.size() != 0);
	endtask

	// One job: mostly a start, a pattern, text built to fit it (sometimes spoiled), a finish.
	task automatic run_job();
		logic [SYM_W-1:0] pat [$];
		logic [SYM_W-1:0] txt [$];
		logic [SYM_W-1:0] c;
		int unsigned      plen;
		int unsigned      j;
		int unsigned      reps;
		int unsigned      idx;
		bit               starred;
		calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 4))
				send_item(op_t'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) != 0)
			send_item(OP_START, SYM_W'($urandom_range(0, 255)));
		plen = ($urandom_range(0, 13) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
		repeat (plen)
			pat.push_back(pick_pattern_byte());
		foreach (pat[i])
			send_item(OP_APPEND, pat[i]);
		j = 0;
		while (j < pat.size() && j < MAX_PATTERN && txt.size() < 40) begin
			c = pat[j];
			starred = (j + 1 < pat.size()) && (pat[j+1] == STAR_BYTE);
			reps = starred ? $urandom_range(0, 3) : 1;
			repeat (reps)
				txt.push_back(c == DOT_BYTE ? pick_text_byte() : c);
			j += starred ? 2 : 1;
		end
		if ($urandom_range(0, 3) == 0) begin
			idx = (txt.size() > 0) ? $urandom_range(0, txt.size() - 1) : 0;
			case ($urandom_range(0, 2))
			0: begin
				if (txt.size() > 0)
					txt[idx] = pick_text_byte();
			end
			1: begin
				txt.insert($urandom_range(0, txt.size()), pick_text_byte());
			end
			default: begin
				if (txt.size() > 0)
					txt.delete(idx);
			end
			endcase
		end
		foreach (txt[i]) begin
			// A pattern byte in the middle of text must be ignored.
			if ($urandom_range(0, 19) == 0)
				send_item(OP_APPEND, pick_pattern_byte());
			send_item(OP_TEXT, txt[i]);
		end
		send_item(OP_FINISH, SYM_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(OP_TEXT, pick_text_byte());
			send_item(OP_FINISH, SYM_W'($urandom_range(0, 255)));
		end
		calm = 1'b0;
	endtask

	// The receiver holds off while finishes arrive back to back, so the result buffer fills.
	task automatic pressure_burst();
		calm = 1'b1;
		hold_req = 1'b1;
		repeat (6)
			send_item(OP_FINISH, SYM_W'($urandom_range(0, 255)));
		calm = 1'b0;
		wait_drained();
	endtask

	initial begin
		int unsigned directed_items;
		bit          pressed;
		clear_job();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_START;
		tag_typed = 1'b0;
		tag_fixed = '0;
		pressed = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset the job is empty: the empty pattern matches the empty text.
		add_row(OP_FINISH, 8'h00, 1, 1'b1, 1'b1, 1'b0);
		add_row(OP_TEXT, 8'h00);
		add_row(OP_FINISH, 8'hFF, 1, 1'b1, 1'b0, 1'b0);
		add_row(OP_START, 8'hFF);
		// A star that opens a token is an ordinary byte.
		add_row(OP_APPEND, STAR_BYTE);
		add_row(OP_APPEND, SYM_A);
		add_row(OP_APPEND, STAR_BYTE);
		add_row(OP_APPEND, DOT_BYTE);
		add_row(OP_APPEND, 8'hFF);
		add_row(OP_FINISH, 8'h00);
		add_row(OP_TEXT, STAR_BYTE);
		add_row(OP_TEXT, SYM_A, 3);
		add_row(OP_TEXT, 8'h00);
		add_row(OP_TEXT, 8'hFF);
		add_row(OP_APPEND, SYM_Q);
		add_row(OP_FINISH, 8'h00);
		add_row(OP_FINISH, 8'hFF);
		add_row(OP_TEXT, 8'h00);
		add_row(OP_FINISH, 8'h00);
		// One byte more than the store holds: no match whatever the text.
		add_row(OP_START, 8'h00);
		add_row(OP_APPEND, SYM_Z, MAX_PATTERN + 1);
		add_row(OP_TEXT, SYM_Z, MAX_PATTERN);
		add_row(OP_FINISH, 8'h00, 1, 1'b1, 1'b0, 1'b1);
		add_row(OP_START, 8'h00);
		add_row(OP_APPEND, DOT_BYTE);
		add_row(OP_APPEND, STAR_BYTE);
		add_row(OP_FINISH, 8'h00);
		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				send_item(dir_rows[i].op, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();
		directed_items = items_sent;

		while (items_sent < directed_items + RANDOM_ITEMS) begin
			if (!pressed && items_sent >= directed_items + RANDOM_ITEMS / 2) begin
				pressure_burst();
				pressed = 1'b1;
			end
			run_job();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d items (%0d directed), checked %0d verdicts: %0d matches, %0d overflows.",
		         items_sent, directed_items, verdicts_seen, matches_seen, overflows_seen);
		$display("Random gaps and stalls on both sides, one %0d-cycle receiver hold-off.",
		         HOLD_CYCLES);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(64'd12 * LIMIT_CYCLES);
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/wspm_pkg.sv
hw/rtl/wspm_cell.sv
hw/rtl/wspm_skid.sv
hw/rtl/wildcard_star_pattern_matcher.sv
hw/rtl/wspm_checker.sv
bench/wildcard_star_pattern_matcher_tb.sv
